// File: rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, codes, keyword tables and character classes of the tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

  typedef enum logic [2:0] {
    KIND_IDENT     = 3'd0,
    KIND_NUMBER    = 3'd1,
    KIND_OPERATOR  = 3'd2,
    KIND_KEYWORD   = 3'd3,
    KIND_SEPARATOR = 3'd4,
    KIND_END       = 3'd5,
    KIND_ERROR     = 3'd6
  } token_kind_t;

  localparam int NUM_KW = 4;

  // keyword spellings, zero padded; row order gives the keyword code
  localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
    '{8'h64, 8'h6f, 8'h75, 8'h62, 8'h6c, 8'h65, 8'h00, 8'h00},  // double
    '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // if
    '{8'h65, 8'h6c, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},  // else
    '{8'h70, 8'h72, 8'h69, 8'h6e, 8'h74, 8'h00, 8'h00, 8'h00}   // print
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd6, 3'd2, 3'd4, 3'd5};

  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;
  localparam logic [7:0] CHAR_DOT        = 8'h2e;

  typedef struct packed {
    token_kind_t  kind;
    logic [1:0]   keyword_code;
    logic [7:0]   symbol_char;
    logic [31:0]  token_start;
    logic [15:0]  token_length;
    logic         last_of_run;
  } tok_rec_t;

  // up to two records per input item, packed from first
  typedef struct packed {
    logic [1:0] count;
    tok_rec_t   first;
    tok_rec_t   second;
  } scan_res_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic is_operator(input logic [7:0] c);
    return c == 8'h2b || c == 8'h2d || c == 8'h2a || c == 8'h2f ||
           c == 8'h3d || c == 8'h3c || c == 8'h3e;
  endfunction

  function automatic logic is_separator(input logic [7:0] c);
    return c == 8'h28 || c == 8'h29 || c == 8'h7b || c == 8'h7d || c == 8'h3b;
  endfunction

endpackage

// File: rtl/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming lexer: source bytes in, token records (kind, start, length) out.
// ----------------------------------------------------------------------------
// One source byte is taken per clock while input ready is high. The scanner
// updates its state in the cycle the byte is accepted and writes the records
// it causes into a four-entry result queue. The queue sends one record per
// cycle while the output is ready; records are registered in the queue before
// they go out. A byte that closes a pending identifier or number and is itself
// a token causes two records. Between two such bytes there is always one that
// causes none, so while the output is ready the text streams at one byte per
// cycle. Input ready drops while fewer than two queue entries are free, which
// only happens under output back-pressure. An unknown byte emits an error
// record and the block takes bytes without output until reset; an end marker
// flushes the pending token, emits end of input and restarts offsets at zero.
module source_text_tokenizer import stt_pkg::*; #(
  parameter int OFFSET_BITS = 32,
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_value[7:0]
  input  logic        s_axis_tlast,   // is_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // symbol_char[7:0], token_start[39:8],
                                      // token_length[55:40]
  output logic [4:0]  m_axis_tuser,   // token_kind[2:0], keyword_code[4:3]
  output logic        m_axis_tlast    // last_of_run
);

  scan_res_t scan_res;
  tok_rec_t  head;
  logic      in_fire;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  stt_scan #(
    .OFFSET_BITS(OFFSET_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .in_byte (s_axis_tdata),
    .in_end  (s_axis_tlast),
    .res     (scan_res)
  );

  stt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (scan_res),
    .room      (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_rec   (head)
  );

  assign m_axis_tdata = {head.token_length, head.token_start, head.symbol_char};
  assign m_axis_tuser = {head.keyword_code, head.kind};
  assign m_axis_tlast = head.last_of_run;

endmodule

// File: rtl/stt_scan.sv
// ----------------------------------------------------------------------------
// stt_scan
// Scanner state and per-byte token logic; yields up to two records per item.
// ----------------------------------------------------------------------------
module stt_scan import stt_pkg::*; #(
  parameter int OFFSET_BITS = 32,
  parameter int LENGTH_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  output scan_res_t  res
);

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_NUMBER = 2'd2,
    MODE_HALT   = 2'd3
  } mode_t;

  mode_t                   mode, mode_next;
  logic [OFFSET_BITS-1:0]  pending_start, pending_start_next;
  logic [LENGTH_BITS-1:0]  pending_length, pending_length_next;
  logic [NUM_KW-1:0]       candidates, candidates_next;
  logic [OFFSET_BITS-1:0]  byte_offset, byte_offset_next;

  logic [NUM_KW-1:0]       ext_match, begin_match;
  logic [LENGTH_BITS-1:0]  length_inc;
  logic [OFFSET_BITS-1:0]  offset_inc;
  logic [31:0]             offset_out, pstart_out;
  logic [15:0]             plen_out;
  logic                    pending, cont;
  logic                    have_flush, have_single;
  tok_rec_t                flush_rec, single_rec;

  always_comb begin
    for (int k = 0; k < NUM_KW; k++) begin
      ext_match[k] = (pending_length < LENGTH_BITS'(KW_LEN[k])) &&
                     (KW_TEXT[k][pending_length[2:0]] == in_byte);
      begin_match[k] = (KW_TEXT[k][0] == in_byte);
    end
  end

  assign length_inc = (pending_length == '1) ? pending_length : pending_length + 1'b1;
  assign offset_inc = (byte_offset == '1) ? byte_offset : byte_offset + 1'b1;

  // clamp internal widths to the record field widths
  assign offset_out = (64'(byte_offset) > 64'hffff_ffff) ? 32'hffff_ffff : 32'(byte_offset);
  assign pstart_out = (64'(pending_start) > 64'hffff_ffff) ? 32'hffff_ffff
                                                          : 32'(pending_start);
  assign plen_out   = (32'(pending_length) > 32'h0000_ffff) ? 16'hffff : 16'(pending_length);

  assign pending = (mode == MODE_IDENT) || (mode == MODE_NUMBER);
  assign cont = ((mode == MODE_IDENT) &&
                 (is_letter(in_byte) || is_digit(in_byte) || in_byte == CHAR_UNDERSCORE)) ||
                ((mode == MODE_NUMBER) && (is_digit(in_byte) || in_byte == CHAR_DOT));

  always_comb begin
    flush_rec              = '0;
    flush_rec.kind         = (mode == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT;
    flush_rec.token_start  = pstart_out;
    flush_rec.token_length = plen_out;
    if (mode == MODE_IDENT) begin
      for (int j = 0; j < NUM_KW; j++) begin
        if (candidates[j] && pending_length == LENGTH_BITS'(KW_LEN[j])) begin
          flush_rec.kind         = KIND_KEYWORD;
          flush_rec.keyword_code = 2'(j);
        end
      end
    end
  end

  always_comb begin
    mode_next           = mode;
    pending_start_next  = pending_start;
    pending_length_next = pending_length;
    candidates_next     = candidates;
    byte_offset_next    = byte_offset;
    have_flush          = 1'b0;
    have_single         = 1'b0;
    single_rec              = '0;
    single_rec.token_start  = offset_out;
    single_rec.token_length = 16'd1;
    single_rec.symbol_char  = in_byte;

    if (in_fire && mode != MODE_HALT) begin
      if (in_end) begin
        have_flush  = pending;
        have_single = 1'b1;
        single_rec.kind         = KIND_END;
        single_rec.symbol_char  = '0;
        single_rec.token_length = '0;
        mode_next           = MODE_IDLE;
        pending_start_next  = '0;
        pending_length_next = '0;
        candidates_next     = '1;
        byte_offset_next    = '0;
      end else begin
        byte_offset_next = offset_inc;
        if (cont) begin
          pending_length_next = length_inc;
          candidates_next     = candidates & ext_match;
        end else begin
          have_flush = pending;
          if (pending) begin
            mode_next           = MODE_IDLE;
            pending_length_next = '0;
            candidates_next     = '1;
          end
          if (is_space(in_byte)) begin
            // dropped
          end else if (is_letter(in_byte) || is_digit(in_byte) || in_byte == CHAR_DOT) begin
            mode_next           = is_letter(in_byte) ? MODE_IDENT : MODE_NUMBER;
            pending_start_next  = byte_offset;
            pending_length_next = LENGTH_BITS'(1);
            candidates_next     = begin_match;
          end else begin
            have_single = 1'b1;
            if (is_operator(in_byte)) begin
              single_rec.kind = KIND_OPERATOR;
            end else if (is_separator(in_byte)) begin
              single_rec.kind = KIND_SEPARATOR;
            end else begin
              single_rec.kind = KIND_ERROR;
              mode_next       = MODE_HALT;
            end
          end
        end
      end
    end
  end

  always_comb begin
    res        = '0;
    res.count  = 2'(have_flush) + 2'(have_single);
    res.first  = have_flush ? flush_rec : single_rec;
    res.first.last_of_run = !(have_flush && have_single);
    res.second = single_rec;
    res.second.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      pending_start  <= '0;
      pending_length <= '0;
      candidates     <= '1;
      byte_offset    <= '0;
    end else begin
      mode           <= mode_next;
      pending_start  <= pending_start_next;
      pending_length <= pending_length_next;
      candidates     <= candidates_next;
      byte_offset    <= byte_offset_next;
    end
  end

endmodule

// File: rtl/stt_queue.sv
// ----------------------------------------------------------------------------
// stt_queue
// Small queue; takes up to two records per cycle, gives one per ready cycle.
// ----------------------------------------------------------------------------
module stt_queue import stt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  scan_res_t push,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output tok_rec_t  out_rec
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  tok_rec_t         entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign out_valid = (count != '0);
  assign out_rec   = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  // room for a worst-case item of two records
  assign room      = (count <= CNT_W'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + 1'b1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

endmodule

// File: rtl/stt_checker.sv
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks of the tokenizer's output records.
// ----------------------------------------------------------------------------
module stt_checker import stt_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [4:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  logic [2:0] kind;
  assign kind = m_axis_tuser[2:0];

  // a stalled output item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output item changed while stalled");

  // end of input closes the run and has no length
  a_end_rec: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && kind == KIND_END |->
      m_axis_tlast && m_axis_tdata[55:40] == 16'd0 && m_axis_tdata[7:0] == 8'd0)
    else $error("malformed end record");

  // single-byte tokens carry their byte and length one
  a_single_rec: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (kind == KIND_OPERATOR || kind == KIND_SEPARATOR ||
                      kind == KIND_ERROR) |->
      m_axis_tdata[55:40] == 16'd1 && m_axis_tlast)
    else $error("malformed single-byte token record");

  // keyword code only on keywords, symbol only on single-byte tokens
  a_word_rec: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (kind == KIND_IDENT || kind == KIND_NUMBER ||
                      kind == KIND_KEYWORD) |->
      m_axis_tdata[7:0] == 8'd0 && m_axis_tdata[55:40] != 16'd0 &&
      (kind == KIND_KEYWORD || m_axis_tuser[4:3] == 2'd0))
    else $error("malformed word token record");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (.*);

// File: test/source_text_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_tb
// Self-checking bench for the streaming tokenizer. Source bytes go in on the
// slave stream with random bursts and gaps. A scanner model built into the
// bench predicts the token records, and each record taken from the master
// stream is compared field by field against the oldest prediction. The output
// side stalls on its own changing pattern and at one point holds off long
// enough to back the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module source_text_tokenizer_tb;
  import stt_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_BYTES  = 1350;
  localparam int SETTLE_CYCLES = 20;
  localparam logic [15:0] LEN_MAX = 16'hffff;
  localparam logic [31:0] OFS_MAX = 32'hffff_ffff;

  typedef enum logic [1:0] {
    SCAN_IDLE   = 2'd0,
    SCAN_IDENT  = 2'd1,
    SCAN_NUMBER = 2'd2,
    SCAN_HALT   = 2'd3
  } scan_mode_t;

  typedef struct {
    token_kind_t kind;
    logic [1:0]  keyword_code;
    logic [7:0]  symbol_char;
    logic [31:0] token_start;
    logic [15:0] token_length;
    logic        last_of_run;
  } token_rec_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic [4:0]  m_axis_tuser;
  logic        m_axis_tlast;

  source_text_tokenizer i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // scanner state mirrored by the bench
  scan_mode_t  scan_mode;
  logic [31:0] tok_start;
  logic [15:0] tok_len;
  logic [3:0]  kw_live;
  logic [31:0] next_offset;

  string keyword_text [4] = '{"double", "if", "else", "print"};
  string op_set  = "+-*/=<>";
  string sep_set = "(){};";

  token_rec_t expected_tokens [$];
  token_rec_t want_tok;

  int errors;
  int bytes_sent;
  int tokens_checked;
  int cycle_count;
  int burst_left;
  int gap_max;
  int hold_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- scanner model

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic in_set(string s, logic [7:0] c);
    for (int i = 0; i < s.len(); i++)
      if (s[i] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic is_known(logic [7:0] c);
    return is_alpha(c) || is_num(c) || c == "." || is_blank(c) ||
           in_set(op_set, c) || in_set(sep_set, c);
  endfunction

  function automatic void reset_scan();
    scan_mode   = SCAN_IDLE;
    tok_start   = '0;
    tok_len     = '0;
    kw_live     = 4'hf;
    next_offset = '0;
  endfunction

  function automatic void push_token(token_kind_t kind, logic [1:0] code, logic [7:0] sym,
                                     logic [31:0] start, logic [15:0] len);
    token_rec_t t;
    t.kind         = kind;
    t.keyword_code = code;
    t.symbol_char  = sym;
    t.token_start  = start;
    t.token_length = len;
    t.last_of_run  = 1'b0;
    expected_tokens = {expected_tokens, t};
  endfunction

  // drop keyword candidates that no longer match as a prefix, then count the byte
  function automatic void extend_pending(logic [7:0] c);
    for (int k = 0; k < 4; k++)
      if (tok_len >= keyword_text[k].len() || keyword_text[k][tok_len] != c)
        kw_live[k] = 1'b0;
    if (tok_len != LEN_MAX) tok_len++;
  endfunction

  function automatic void start_pending(scan_mode_t mode, logic [7:0] c);
    scan_mode = mode;
    tok_start = next_offset;
    tok_len   = '0;
    kw_live   = 4'hf;
    extend_pending(c);
  endfunction

  function automatic int flush_pending();
    token_kind_t kind;
    logic [1:0]  code;
    code = 2'd0;
    if (scan_mode == SCAN_IDENT) begin
      kind = KIND_IDENT;
      for (int j = 0; j < 4; j++)
        if (kw_live[j] && tok_len == keyword_text[j].len()) begin
          kind = KIND_KEYWORD;
          code = 2'(j);
        end
    end else if (scan_mode == SCAN_NUMBER) begin
      kind = KIND_NUMBER;
    end else begin
      return 0;
    end
    push_token(kind, code, 8'h00, tok_start, tok_len);
    scan_mode = SCAN_IDLE;
    tok_len   = '0;
    kw_live   = 4'hf;
    return 1;
  endfunction

  // predict the records caused by one accepted item
  function automatic void scan_byte(logic [7:0] c, logic marker);
    int n;
    n = 0;
    if (scan_mode == SCAN_HALT) return;
    if (marker) begin
      n += flush_pending();
      push_token(KIND_END, 2'd0, 8'h00, next_offset, 16'd0);
      expected_tokens[expected_tokens.size() - 1].last_of_run = 1'b1;
      reset_scan();
      return;
    end
    if (scan_mode == SCAN_IDENT && (is_alpha(c) || is_num(c) || c == "_")) begin
      extend_pending(c);
    end else if (scan_mode == SCAN_NUMBER && (is_num(c) || c == ".")) begin
      extend_pending(c);
    end else begin
      n += flush_pending();
      if (is_blank(c)) begin
        // dropped
      end else if (is_alpha(c)) begin
        start_pending(SCAN_IDENT, c);
      end else if (is_num(c) || c == ".") begin
        start_pending(SCAN_NUMBER, c);
      end else if (in_set(op_set, c)) begin
        push_token(KIND_OPERATOR, 2'd0, c, next_offset, 16'd1);
        n++;
      end else if (in_set(sep_set, c)) begin
        push_token(KIND_SEPARATOR, 2'd0, c, next_offset, 16'd1);
        n++;
      end else begin
        push_token(KIND_ERROR, 2'd0, c, next_offset, 16'd1);
        n++;
        scan_mode = SCAN_HALT;
      end
    end
    if (next_offset != OFS_MAX) next_offset++;
    if (n > 0) expected_tokens[expected_tokens.size() - 1].last_of_run = 1'b1;
  endfunction

  // ---------------------------------------------------------------- result check

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_tokens.size() == 0) begin
        $error("token record with none pending: kind %0d start %0d",
               m_axis_tuser[2:0], m_axis_tdata[39:8]);
        errors++;
      end else begin
        want_tok = expected_tokens.pop_front();
        check_field("token_kind", want_tok.kind, m_axis_tuser[2:0]);
        check_field("keyword_code", want_tok.keyword_code, m_axis_tuser[4:3]);
        check_field("symbol_char", want_tok.symbol_char, m_axis_tdata[7:0]);
        check_field("token_start", want_tok.token_start, m_axis_tdata[39:8]);
        check_field("token_length", want_tok.token_length, m_axis_tdata[55:40]);
        check_field("last_of_run", want_tok.last_of_run, m_axis_tlast);
        tokens_checked++;
      end
    end
  end

  // output side: changing stall pattern plus a long hold-off on request
  initial begin : output_stall
    int hold_left;
    int mode_left;
    int mode;
    hold_left = 0;
    mode_left = 0;
    mode      = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      @(negedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(32, 256);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          2: m_axis_tready <= ($urandom_range(0, 9) < 3);
          default: m_axis_tready <= ((mode_left / 5) % 2 == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // called at a falling edge, returns at the falling edge after the handshake
  task automatic send_item(input logic [7:0] c, input logic marker);
    if (gap_max > 0 && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= marker;
    do @(posedge clk); while (!s_axis_tready);
    scan_byte(c, marker);
    bytes_sent++;
    if (burst_left > 0) burst_left--;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_tokens.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return "_";
  endfunction

  function automatic logic [7:0] blank_char();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? 8'h20 : 8'(8'h09 + r);
  endfunction

  task automatic test_keywords();
    gap_max = 4;
    send_text("double else\nprint If doubles");
    send_item(8'hff, 1'b1);
    send_text("els if");
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_symbols();
    gap_max = 2;
    send_text("x+-*/=<>(){};9.5 \t\v\f\r.");
    send_item(8'h5a, 1'b1);
    // end marker on an empty stream
    send_item(8'ha5, 1'b1);
  endtask

  task automatic test_long_token();
    gap_max = 0;
    send_text("3 q");
    for (int i = 0; i < 200; i++) send_item((i % 3 == 0) ? "_" : "7", 1'b0);
    send_text(" 1");
    send_item(8'h00, 1'b1);
  endtask

  // long output hold-off while the input keeps offering two-record bytes
  task automatic test_backpressure();
    gap_max  = 0;
    hold_req = 300;
    for (int i = 0; i < 40; i++) send_text((i % 2) ? "a+" : "b(");
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_random_text(input int n_bytes);
    int first;
    int next_switch;
    int choice;
    int k;
    int len;
    logic [7:0] c;
    first       = bytes_sent;
    next_switch = bytes_sent;
    while (bytes_sent - first < n_bytes) begin
      if (bytes_sent >= next_switch) begin
        case ($urandom_range(0, 2))
          0: gap_max = 0;
          1: gap_max = 3;
          default: gap_max = 12;
        endcase
        next_switch = bytes_sent + $urandom_range(40, 160);
      end
      choice = $urandom_range(0, 99);
      if (choice < 16) begin
        k   = $urandom_range(0, 3);
        len = keyword_text[k].len();
        if ($urandom_range(0, 4) == 0) len = $urandom_range(1, len);
        for (int i = 0; i < len; i++) send_item(keyword_text[k][i], 1'b0);
      end else if (choice < 36) begin
        send_item(8'($urandom_range(0, 1) ? "a" + $urandom_range(0, 25)
                                          : "A" + $urandom_range(0, 25)), 1'b0);
        repeat ($urandom_range(0, 8)) send_item(word_char(), 1'b0);
      end else if (choice < 50) begin
        repeat ($urandom_range(1, 8))
          send_item(($urandom_range(0, 4) == 0) ? "." : 8'("0" + $urandom_range(0, 9)), 1'b0);
      end else if (choice < 62) begin
        send_item(op_set[$urandom_range(0, op_set.len() - 1)], 1'b0);
      end else if (choice < 72) begin
        send_item(sep_set[$urandom_range(0, sep_set.len() - 1)], 1'b0);
      end else if (choice < 87) begin
        repeat ($urandom_range(1, 3)) send_item(blank_char(), 1'b0);
      end else if (choice < 92) begin
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        // any byte the scanner knows, outside a token's usual shape
        do c = 8'($urandom_range(0, 127)); while (!is_known(c));
        send_item(c, 1'b0);
      end
    end
  endtask

  // an unknown byte halts the block for the rest of the run
  task automatic test_halt_on_unknown();
    gap_max = 3;
    send_text("ab");
    send_item(8'($urandom_range(128, 255)), 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b1);
    repeat (10) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    errors        = 0;
    bytes_sent    = 0;
    tokens_checked = 0;
    cycle_count   = 0;
    burst_left    = 0;
    gap_max       = 0;
    hold_req      = 0;
    reset_scan();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_keywords();
    test_symbols();
    test_long_token();
    test_backpressure();
    test_random_text(RANDOM_BYTES);
    test_halt_on_unknown();
    wait_drained();

    $display("sent %0d source bytes and checked %0d token records", bytes_sent,
             tokens_checked);
    $display("covered keywords, all symbols, end markers, long tokens, "
             , "output backpressure and halt on an unknown byte");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
